// ===== hw/rtl/lea128_block_encrypt_defines.svh =====
// Assertion macros for the block cipher RTL.
// Each macro expects the signals clock and reset in the scope where it is used.
`ifndef LEA128_BLOCK_ENCRYPT_DEFINES_SVH
`define LEA128_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define LEA_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lea128 assertion failed");

`define LEA_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lea128 assertion failed");

`else

`define LEA_ASSERT_IMPLY(label, pre, post)

`define LEA_ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== hw/rtl/lea_pkg.sv =====
package lea_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned BLOCK_WORDS = 4;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef logic [WORD_WIDTH-1:0] lea_word_type;
   typedef logic [BLOCK_WORDS-1:0][WORD_WIDTH-1:0] lea_block_type;
   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] lea_key_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] lea_csr_index_type;

   typedef struct packed {
      logic          valid;
      lea_block_type x;
      lea_key_type   t;
   } lea_stage_type;

   localparam lea_key_type LEA_DELTA = {
      32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
   };

   function automatic lea_word_type rotl32(input lea_word_type v, input logic [4:0] n);
      return (v << n) | (v >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic lea_word_type round_delta(input int unsigned r);
      logic [4:0] n;
      logic [1:0] sel;
      n = r[4:0];
      sel = r[1:0];
      return rotl32(LEA_DELTA[sel], n);
   endfunction

endpackage

// ===== hw/rtl/lea_round_cell.sv =====
module lea_round_cell
   import lea_pkg::*;
#(
   parameter int unsigned ROUND_INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  lea_stage_type stage_in,
   output lea_stage_type stage_out
);

   localparam lea_word_type DELTA_0 = round_delta(ROUND_INDEX);
   localparam lea_word_type DELTA_1 = rotl32(DELTA_0, 5'd1);
   localparam lea_word_type DELTA_2 = rotl32(DELTA_0, 5'd2);
   localparam lea_word_type DELTA_3 = rotl32(DELTA_0, 5'd3);

   logic          valid_ff;
   lea_block_type x_ff;
   lea_block_type x_in;
   lea_key_type   t_ff;
   lea_key_type   t_in;

   always_comb begin
      t_in[0] = rotl32(stage_in.t[0] + DELTA_0, 5'd1);
      t_in[1] = rotl32(stage_in.t[1] + DELTA_1, 5'd3);
      t_in[2] = rotl32(stage_in.t[2] + DELTA_2, 5'd6);
      t_in[3] = rotl32(stage_in.t[3] + DELTA_3, 5'd11);

      x_in[0] = rotl32((stage_in.x[0] ^ t_in[0]) + (stage_in.x[1] ^ t_in[1]), 5'd9);
      x_in[1] = rotl32((stage_in.x[1] ^ t_in[2]) + (stage_in.x[2] ^ t_in[1]), 5'd27);
      x_in[2] = rotl32((stage_in.x[2] ^ t_in[3]) + (stage_in.x[3] ^ t_in[1]), 5'd29);
      x_in[3] = stage_in.x[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         t_ff <= t_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.x = x_ff;
   assign stage_out.t = t_ff;

endmodule

// ===== hw/rtl/lea128_block_encrypt.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/tready     plaintext words 0..3 in req_tdata
// rsp       out        rsp_tvalid/tready     ciphertext words 0..3 in rsp_tdata
// csr       in         csr_wr_en             key word csr_index <= csr_wdata
//
// One block is accepted per cycle unless rsp stalls; every cell registers it.
// Each round is one cell of the chain, and the last cell's register drives rsp.
// Reset clears the key and the valid bit of every cell.
// While a result waits on rsp_tready the whole chain holds and req_tready is low.
`include "lea128_block_encrypt_defines.svh"

module lea128_block_encrypt
   import lea_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // plain_word_0 [31:0], plain_word_1, plain_word_2, plain_word_3 [127:96]
   input  logic [127:0]      req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // cipher_word_0 [31:0], cipher_word_1, cipher_word_2, cipher_word_3 [127:96]
   output logic [127:0]      rsp_tdata,
   input  logic              csr_wr_en,
   input  lea_csr_index_type csr_index,
   input  logic [31:0]       csr_wdata
);

   lea_key_type   key_ff;
   lea_stage_type stage [ROUND_COUNT+1];
   logic          advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   assign advance = !stage[ROUND_COUNT].valid || rsp_tready;
   assign req_tready = advance;

   assign stage[0].valid = req_tvalid;
   assign stage[0].x = req_tdata;
   assign stage[0].t = key_ff;

   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
      lea_round_cell #(
         .ROUND_INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_in (stage[i]),
         .stage_out(stage[i+1])
      );
   end

   assign rsp_tvalid = stage[ROUND_COUNT].valid;
   assign rsp_tdata = stage[ROUND_COUNT].x;

   `LEA_ASSERT_NEXT(a_valid_shift, advance && !reset, rsp_tvalid == $past(stage[ROUND_COUNT-1].valid))
   `LEA_ASSERT_NEXT(a_stall_holds, !advance && !reset, $stable(rsp_tdata) && rsp_tvalid)
   `LEA_ASSERT_IMPLY(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready)

endmodule

// ===== verif/lea128_cipher_checker.sv =====
module lea128_cipher_checker
   import lea_pkg::*;
#(
   parameter int unsigned ROUND_COUNT = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  lea_block_type     req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  lea_block_type     rsp_tdata,
   input  logic              csr_wr_en,
   input  lea_csr_index_type csr_index,
   input  logic [31:0]       csr_wdata,
   output int unsigned       error_count,
   output int unsigned       pending_count,
   output int unsigned       checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam lea_word_type KEY_CONST [4] = '{
      32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
   };

   lea_key_type   cipher_key;
   lea_block_type cipher_queue [$];

   initial begin
      error_count = 0;
      pending_count = 0;
      checked_count = 0;
      cipher_key = '0;
   end

   function automatic lea_word_type rol(input lea_word_type v, input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0) begin
         return v;
      end
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic lea_block_type encrypt_block(input lea_block_type plain,
                                                   input lea_key_type key);
      lea_word_type x0, x1, x2, x3;
      lea_word_type t0, t1, t2, t3;
      lea_word_type d, n0, n1, n2;
      lea_block_type cipher;
      x0 = plain[0];
      x1 = plain[1];
      x2 = plain[2];
      x3 = plain[3];
      t0 = key[0];
      t1 = key[1];
      t2 = key[2];
      t3 = key[3];
      for (int unsigned r = 0; r < ROUND_COUNT; r++) begin
         d = rol(KEY_CONST[r % 4], r);
         t0 = rol(t0 + d, 1);
         t1 = rol(t1 + rol(d, 1), 3);
         t2 = rol(t2 + rol(d, 2), 6);
         t3 = rol(t3 + rol(d, 3), 11);
         n0 = rol((x0 ^ t0) + (x1 ^ t1), 9);
         n1 = rol((x1 ^ t2) + (x2 ^ t1), 27);
         n2 = rol((x2 ^ t3) + (x3 ^ t1), 29);
         x3 = x0;
         x0 = n0;
         x1 = n1;
         x2 = n2;
      end
      cipher[0] = x0;
      cipher[1] = x1;
      cipher[2] = x2;
      cipher[3] = x3;
      return cipher;
   endfunction

   // A block accepted in the same cycle as a key write still sees the old key.
   always @(posedge clock) begin : watch
      lea_block_type expected;
      if (reset) begin
         cipher_key = '0;
         cipher_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            cipher_queue.push_back(encrypt_block(req_tdata, cipher_key));
         end
         if (csr_wr_en) begin
            cipher_key[csr_index] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_queue.size() == 0) begin
               $error("ciphertext transfer with no block outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               expected = cipher_queue.pop_front();
               checked_count++;
               for (int w = 0; w < 4; w++) begin
                  if (rsp_tdata[w] !== expected[w]) begin
                     $error("cipher_word_%0d mismatch: expected %h, actual %h",
                            w, expected[w], rsp_tdata[w]);
                     error_count++;
                  end
               end
            end
         end
      end
      pending_count = cipher_queue.size();
   end

endmodule

// ===== verif/testbench.sv =====
module testbench
   import lea_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LATENCY = 24;
   localparam int unsigned PHASES = 8;
   localparam int unsigned PHASE_BLOCKS = 192;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [127:0]      req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [127:0]      rsp_tdata;
   logic              csr_wr_en = 1'b0;
   lea_csr_index_type csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   int unsigned error_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned key_settings = 0;

   lea128_block_encrypt #(.ROUND_COUNT(LATENCY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   lea128_cipher_checker #(.ROUND_COUNT(LATENCY)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic lea_word_type random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return lea_word_type'(1) << $urandom_range(31);
         3: return ~(lea_word_type'(1) << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   function automatic lea_block_type random_block();
      lea_block_type blk;
      for (int w = 0; w < 4; w++) begin
         blk[w] = random_word();
      end
      return blk;
   endfunction

   function automatic lea_block_type fill_block(input lea_word_type v);
      lea_block_type blk;
      for (int w = 0; w < 4; w++) begin
         blk[w] = v;
      end
      return blk;
   endfunction

   // Called and returning at a falling edge.
   task automatic send_block(input lea_block_type blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= blk;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic load_key(input lea_key_type key);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= lea_csr_index_type'(i);
         csr_wdata <= key[i];
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
      key_settings++;
   endtask

   initial begin
      lea_key_type   phase_key;
      lea_block_type blk;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reset key is all zeros until the first write.
      send_block(fill_block('0));
      send_block(fill_block('1));
      drain();

      phase_key = {32'hf0e1d2c3, 32'hb4a59687, 32'h78695a4b, 32'h3c2d1e0f};
      load_key(phase_key);
      send_block({32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110});
      send_block(fill_block('0));
      drain();

      load_key(fill_block('1));
      send_block(fill_block('0));
      send_block(fill_block('1));
      send_block(fill_block(32'haaaaaaaa));
      send_block(fill_block(32'h55555555));
      send_block(fill_block(32'h80000000));
      send_block(fill_block(32'h00000001));
      for (int w = 0; w < 4; w++) begin
         blk = '0;
         blk[w] = '1;
         send_block(blk);
      end
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 81; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 81; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         case (p)
            0: phase_key = '0;
            1: phase_key = '1;
            2: phase_key = fill_block(32'haaaaaaaa);
            default: phase_key = random_block();
         endcase
         load_key(phase_key);
         for (int i = 0; i < PHASE_BLOCKS; i++) begin
            send_block(random_block());
         end
         drain();
      end

      $display("Encrypted and checked %0d blocks under %0d key settings,",
               checked_count, key_settings);
      $display("with sender gaps and receiver stalls from none to heavy.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
